// File: rtl/core/ukst_pkg.sv
// Package for the unique key set table: shared types and default sizes.
// Used by ukst_cell and unique_key_set_table; depends on nothing else.
`default_nettype none

package ukst_pkg;

  // Default sizes, handed to the top level's parameters.
  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Request operations as carried on the mode field.
  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_EXISTS = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  // Sequencer states: wait for a word, then resolve the compare and update.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MATCH = 1'b1
  } state_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic capture;   // latch this cell's compare result
    logic by_index;  // compare the slot number rather than the key
    logic append;    // the cell at the count position takes the new key
    logic shift;     // cells at or above the hit position take their neighbour's key
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/unique_key_set_table.sv
// A word's compare result is latched in the cell row; the result is then registered at the output
// by the encode-and-update step. No new word is taken until that step completes;
// a held result stalls the update and so the next word.
// Reset clears the key count, sequencer and output valid; the cell contents are
// not cleared, as only slots below the count are ever read.
// Top level of the unique key set table: sequencer, result logic and the cell row.
// Depends on ukst_pkg and ukst_cell.
`default_nettype none

module unique_key_set_table #(
  parameter int CAPACITY  = ukst_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = ukst_pkg::KEY_WIDTH_DEF,
  localparam int CNT_W    = $clog2(CAPACITY + 1),
  localparam int IDX_W    = $clog2(CAPACITY)
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [2:0]            mode,
  input  wire  [KEY_WIDTH-1:0]  key,
  input  wire  [IDX_W-1:0]      slot_index,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  ok,
  output logic                  full_res,
  output logic [CNT_W-1:0]      count,
  output logic [KEY_WIDTH-1:0]  read_value
);

  ukst_pkg::state_t     state;
  ukst_pkg::state_t     state_next;
  ukst_pkg::mode_t      req_mode;
  logic [KEY_WIDTH-1:0] req_key;
  logic [CNT_W-1:0]     stored_count;
  logic [CNT_W-1:0]     stored_count_next;
  ukst_pkg::cell_ctrl_t ctrl;

  logic                 in_acc;
  logic                 done;
  logic                 hit;
  logic [IDX_W-1:0]     pos;
  logic [KEY_WIDTH-1:0] sel_data;
  logic                 res_ok;
  logic                 res_full;
  logic                 do_append;
  logic                 do_shift;

  logic [CAPACITY-1:0]  match_vec;
  logic [KEY_WIDTH-1:0] cell_data [CAPACITY];

  assign in_acc = in_valid && !in_stall;
  assign done   = (state == ukst_pkg::ST_MATCH) && !(out_valid && out_stall);

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ukst_pkg::ST_IDLE:  if (in_acc) state_next = ukst_pkg::ST_MATCH;
      ukst_pkg::ST_MATCH: if (done) state_next = ukst_pkg::ST_IDLE;
      default:            state_next = ukst_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: take a word only when idle, drive the cell row.
  always_comb begin
    in_stall      = (state != ukst_pkg::ST_IDLE);
    ctrl.capture  = in_acc;
    ctrl.by_index = (ukst_pkg::mode_t'(mode) == ukst_pkg::MODE_READ);
    ctrl.append   = done && do_append;
    ctrl.shift    = done && do_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ukst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request word held for the update cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_mode <= ukst_pkg::mode_t'(mode);
      req_key  <= key;
    end
  end

  // The row of cells; on a removal, cells at or above the hit position take their upper neighbour's key.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_WIDTH-1:0] above;
    if (g == CAPACITY - 1) begin : g_top
      assign above = cell_data[g];
    end else begin : g_mid
      assign above = cell_data[g + 1];
    end

    ukst_cell #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH),
      .INDEX     (g)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .key_in   (key),
      .slot     (slot_index),
      .fill     (stored_count),
      .pos      (pos),
      .req_key  (req_key),
      .shift_in (above),
      .data     (cell_data[g]),
      .match    (match_vec[g])
    );
  end

  // At most one cell matches: OR the hit cell's position and key together.
  always_comb begin
    pos      = '0;
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        pos      = pos | IDX_W'(i);
        sel_data = sel_data | cell_data[i];
      end
    end
    hit = |match_vec;
  end

  // Result and count update for the held request.
  always_comb begin
    res_ok            = 1'b0;
    res_full          = 1'b0;
    do_append         = 1'b0;
    do_shift          = 1'b0;
    stored_count_next = stored_count;
    case (req_mode)
      ukst_pkg::MODE_ADD: begin
        if (!hit) begin
          if (stored_count >= CNT_W'(CAPACITY)) begin
            res_full = 1'b1;
          end else begin
            res_ok            = 1'b1;
            do_append         = 1'b1;
            stored_count_next = stored_count + CNT_W'(1);
          end
        end
      end
      ukst_pkg::MODE_EXISTS: begin
        res_ok = hit;
      end
      ukst_pkg::MODE_REMOVE: begin
        if (hit) begin
          res_ok            = 1'b1;
          do_shift          = 1'b1;
          stored_count_next = stored_count - CNT_W'(1);
        end
      end
      ukst_pkg::MODE_CLEAR: begin
        res_ok            = 1'b1;
        stored_count_next = '0;
      end
      ukst_pkg::MODE_READ: begin
        res_ok = hit;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Key count.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
    end else if (done) begin
      stored_count <= stored_count_next;
    end
  end

  // Output register; it holds its word while the far side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      ok         <= res_ok;
      full_res   <= res_full;
      count      <= stored_count_next;
      read_value <= (req_mode == ukst_pkg::MODE_READ) ? sel_data : '0;
    end
  end

`ifndef SYNTHESIS
  // Keys are distinct and slot numbers unique, so at most one cell can match.
  assert property (@(posedge clk) disable iff (rst)
    (state == ukst_pkg::ST_MATCH) |-> $onehot0(match_vec))
    else $error("more than one cell matched");

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(CAPACITY))
    else $error("key count beyond capacity");

  // An accepted word always moves the sequencer into the update cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ukst_pkg::ST_MATCH))
    else $error("accepted word not processed");

  // A rejected add for fullness never also reports success.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ok && full_res))
    else $error("result both ok and full");

  // The count moves by at most one except on a clear.
  assert property (@(posedge clk) disable iff (rst)
    (done && req_mode != ukst_pkg::MODE_CLEAR) |=>
      (stored_count == $past(stored_count) ||
       stored_count == $past(stored_count) + CNT_W'(1) ||
       stored_count == $past(stored_count) - CNT_W'(1)))
    else $error("key count jumped");
`endif

endmodule

`default_nettype wire

// File: rtl/core/ukst_cell.sv
// One slot of the key row: holds a key, compares it and shifts it down on removal.
// Depends on ukst_pkg for the control struct.
`default_nettype none

module ukst_cell #(
  parameter int CAPACITY  = ukst_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = ukst_pkg::KEY_WIDTH_DEF,
  parameter int INDEX     = 0,
  localparam int CNT_W    = $clog2(CAPACITY + 1),
  localparam int IDX_W    = $clog2(CAPACITY)
) (
  input  wire                        clk,
  input  wire ukst_pkg::cell_ctrl_t  ctrl,
  input  wire  [KEY_WIDTH-1:0]       key_in,
  input  wire  [IDX_W-1:0]           slot,
  input  wire  [CNT_W-1:0]           fill,
  input  wire  [IDX_W-1:0]           pos,
  input  wire  [KEY_WIDTH-1:0]       req_key,
  input  wire  [KEY_WIDTH-1:0]       shift_in,
  output logic [KEY_WIDTH-1:0]       data,
  output logic                       match
);

  logic live;
  logic at_fill;
  logic at_or_above;
  logic hit_next;

  // A slot holds a key only below the fill count.
  assign live        = CNT_W'(INDEX) < fill;
  assign at_fill     = CNT_W'(INDEX) == fill;
  assign at_or_above = IDX_W'(INDEX) >= pos;

  // Compare either the slot number (read) or the stored key.
  assign hit_next = live && (ctrl.by_index ? (IDX_W'(INDEX) == slot) : (data == key_in));

  // Stored key: appended at the fill position, or taken from the neighbour above.
  always_ff @(posedge clk) begin
    if (ctrl.append && at_fill) begin
      data <= req_key;
    end else if (ctrl.shift && at_or_above) begin
      data <= shift_in;
    end
  end

  // Compare result, latched when a word is accepted.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match <= hit_next;
    end
  end

endmodule

`default_nettype wire
